// ===== src/qqo_pkg.sv =====
// ============================================================================
// qqo_pkg
// Shared constants and helpers for the quad/quad overlap test pipeline.
// ============================================================================
`default_nettype none

package qqo_pkg;

   // Coordinate parameter default and its legal limits
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int COORD_BITS_MIN     = 8;
   localparam int COORD_BITS_MAX     = 31;

   // Packed vertex word: x in the low half, y in the high half
   localparam int FIELD_BITS = 32;
   localparam int HALF_BITS  = 16;

   // Geometry counts
   localparam int QUAD_VERTS = 4;                  // vertices per quad
   localparam int NUM_VERTS  = 2 * QUAD_VERTS;     // vertices per transaction
   localparam int NUM_POINTS = NUM_VERTS;          // points tested for containment
   localparam int NUM_SIDE   = NUM_POINTS * QUAD_VERTS; // edge-side cross products

   // Cross product slots after the edge-side ones: segment crossing terms
   localparam int CROSS_DEN  = NUM_SIDE;           // cross(r, s)
   localparam int CROSS_N1   = NUM_SIDE + 1;       // cross(s, w)
   localparam int CROSS_N2   = NUM_SIDE + 2;       // cross(r, w)
   localparam int NUM_CROSS  = NUM_SIDE + 3;

   // Vertex slots in a transaction
   localparam int VERT_A1 = 0;
   localparam int VERT_D1 = 3;
   localparam int VERT_A2 = 4;
   localparam int VERT_C2 = 6;
   localparam int VERT_D2 = 7;

   // Bits actually used per coordinate
   function automatic int coord_width(input int coord_bits);
      return (coord_bits < HALF_BITS) ? coord_bits : HALF_BITS;
   endfunction

endpackage

`default_nettype wire

// ===== src/qqo_if.sv =====
// ============================================================================
// qqo_if
// Valid/ready channels for the overlap test: request pairs and hit results.
// ============================================================================
`default_nettype none

interface qqo_req_if;
   import qqo_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] quad_one_a;
   logic [FIELD_BITS-1:0] quad_one_b;
   logic [FIELD_BITS-1:0] quad_one_c;
   logic [FIELD_BITS-1:0] quad_one_d;
   logic [FIELD_BITS-1:0] quad_two_a;
   logic [FIELD_BITS-1:0] quad_two_b;
   logic [FIELD_BITS-1:0] quad_two_c;
   logic [FIELD_BITS-1:0] quad_two_d;

   modport source (
      output valid, quad_one_a, quad_one_b, quad_one_c, quad_one_d,
             quad_two_a, quad_two_b, quad_two_c, quad_two_d,
      input  ready
   );

   modport sink (
      input  valid, quad_one_a, quad_one_b, quad_one_c, quad_one_d,
             quad_two_a, quad_two_b, quad_two_c, quad_two_d,
      output ready
   );
endinterface

interface qqo_rsp_if;
   logic valid;
   logic ready;
   logic overlap_hit;

   modport source (
      output valid, overlap_hit,
      input  ready
   );

   modport sink (
      input  valid, overlap_hit,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/quad_quad_overlap_test.sv =====
// ============================================================================
// quad_quad_overlap_test
// Overlap test for two quadrilaterals: vertex containment both ways plus
// one edge-crossing test, as a four-stage pipeline.
// ============================================================================
// Usage:
//   req_ch carries one transaction per quad pair: eight vertex words, each
//   with x in bits 15..0 and y in bits 31..16 (two's complement, low
//   min(COORD_BITS,16) bits of each half used). rsp_ch returns one
//   overlap_hit flag per transaction, in order.
//   Stages: 1 unpack and differences, 2 multiplies, 3 cross products,
//   4 sign/interval tests into the result register.
//   Path: an accepted transaction passes the operand, product, cross
//   product and result registers; rsp_ch.valid then shows its flag.
//   Throughput: one transaction per cycle unless stalled; each stage has
//   its own valid bit and takes a new one when empty or its successor moves.
//   Reset clears all stage valid bits; no results are pending after it.
//   When rsp_ch.ready is low the result register holds, the stall spreads
//   back one stage at a time, and req_ch.ready drops once all four stages
//   hold transactions. Nothing is dropped or repeated.
// ============================================================================
`default_nettype none

module quad_quad_overlap_test #(
   parameter int COORD_BITS = qqo_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   qqo_req_if.sink    req_ch,
   qqo_rsp_if.source  rsp_ch
);
   import qqo_pkg::*;

   localparam int CW = coord_width(COORD_BITS);
   localparam int DW = CW + 1;
   localparam int XW = 2 * DW + 1;

   logic [NUM_VERTS-1:0][FIELD_BITS-1:0] vert_words;

   logic                          opd_valid;
   logic                          opd_ready;
   logic [NUM_CROSS-1:0][DW-1:0]  ax;
   logic [NUM_CROSS-1:0][DW-1:0]  ay;
   logic [NUM_CROSS-1:0][DW-1:0]  bx;
   logic [NUM_CROSS-1:0][DW-1:0]  by;

   logic                          crs_valid;
   logic                          crs_ready;
   logic [NUM_CROSS-1:0][XW-1:0]  crs;

   // Vertex words in slot order
   assign vert_words[0] = req_ch.quad_one_a;
   assign vert_words[1] = req_ch.quad_one_b;
   assign vert_words[2] = req_ch.quad_one_c;
   assign vert_words[3] = req_ch.quad_one_d;
   assign vert_words[4] = req_ch.quad_two_a;
   assign vert_words[5] = req_ch.quad_two_b;
   assign vert_words[6] = req_ch.quad_two_c;
   assign vert_words[7] = req_ch.quad_two_d;

   // Stage 1
   qqo_operands #(
      .COORD_BITS (COORD_BITS)
   ) u_operands (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_ch.valid),
      .up_ready   (req_ch.ready),
      .vert_words (vert_words),
      .dn_valid   (opd_valid),
      .dn_ready   (opd_ready),
      .ax         (ax),
      .ay         (ay),
      .bx         (bx),
      .by         (by)
   );

   // Stages 2 and 3
   qqo_cross #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock    (clock),
      .reset    (reset),
      .up_valid (opd_valid),
      .up_ready (opd_ready),
      .ax       (ax),
      .ay       (ay),
      .bx       (bx),
      .by       (by),
      .dn_valid (crs_valid),
      .dn_ready (crs_ready),
      .crs      (crs)
   );

   // Stage 4 and result register
   qqo_decide #(
      .COORD_BITS (COORD_BITS)
   ) u_decide (
      .clock    (clock),
      .reset    (reset),
      .up_valid (crs_valid),
      .up_ready (crs_ready),
      .crs      (crs),
      .dn_valid (rsp_ch.valid),
      .dn_ready (rsp_ch.ready),
      .hit      (rsp_ch.overlap_hit)
   );

endmodule

`default_nettype wire

// ===== src/qqo_operands.sv =====
// ============================================================================
// qqo_operands
// Stage 1: unpacks vertex coordinates and forms the two difference vectors
// of every cross product (edge vector and point-relative vector).
// ============================================================================
`default_nettype none

module qqo_operands #(
   parameter int COORD_BITS = qqo_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // upstream
   input  wire logic up_valid,
   output logic      up_ready,
   input  wire logic [qqo_pkg::NUM_VERTS-1:0][qqo_pkg::FIELD_BITS-1:0] vert_words,
   // downstream
   output logic      dn_valid,
   input  wire logic dn_ready,
   output logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] ax,
   output logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] ay,
   output logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] bx,
   output logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] by
);
   import qqo_pkg::*;

   localparam int CW = coord_width(COORD_BITS);   // coordinate bits used
   localparam int DW = CW + 1;                    // difference bits

   wire logic signed [NUM_VERTS-1:0][DW-1:0] cx;
   wire logic signed [NUM_VERTS-1:0][DW-1:0] cy;
   wire logic [NUM_CROSS-1:0][DW-1:0] ax_in;
   wire logic [NUM_CROSS-1:0][DW-1:0] ay_in;
   wire logic [NUM_CROSS-1:0][DW-1:0] bx_in;
   wire logic [NUM_CROSS-1:0][DW-1:0] by_in;

   logic                          valid_ff;
   logic                          valid_in;
   logic [NUM_CROSS-1:0][DW-1:0]  ax_ff;
   logic [NUM_CROSS-1:0][DW-1:0]  ay_ff;
   logic [NUM_CROSS-1:0][DW-1:0]  bx_ff;
   logic [NUM_CROSS-1:0][DW-1:0]  by_ff;

   // Unpack: low CW bits of each half, sign extended by one bit
   for (genvar v = 0; v < NUM_VERTS; v++) begin : g_unpack
      assign cx[v] = DW'($signed(vert_words[v][CW-1:0]));
      assign cy[v] = DW'($signed(vert_words[v][HALF_BITS+CW-1:HALF_BITS]));
   end

   // Edge-side operands: cross(V[j+1]-V[j], P-V[j+1]) for every point and edge.
   // Points 0..3 are the second quad tested against the first, 4..7 the reverse.
   for (genvar pt = 0; pt < NUM_POINTS; pt++) begin : g_point
      localparam int QB = (pt < QUAD_VERTS) ? 0 : QUAD_VERTS;
      localparam int PV = (pt < QUAD_VERTS) ? pt + QUAD_VERTS : pt - QUAD_VERTS;
      for (genvar j = 0; j < QUAD_VERTS; j++) begin : g_edge
         localparam int K  = pt * QUAD_VERTS + j;
         localparam int V0 = QB + j;
         localparam int V1 = QB + ((j + 1) % QUAD_VERTS);
         assign ax_in[K] = cx[V1] - cx[V0];
         assign ay_in[K] = cy[V1] - cy[V0];
         assign bx_in[K] = cx[PV] - cx[V1];
         assign by_in[K] = cy[PV] - cy[V1];
      end
   end

   // Segment D1->A1 against C2->D2: r = A1-D1, s = D2-C2, w = D1-C2
   assign ax_in[CROSS_DEN] = cx[VERT_A1] - cx[VERT_D1];   // r
   assign ay_in[CROSS_DEN] = cy[VERT_A1] - cy[VERT_D1];
   assign bx_in[CROSS_DEN] = cx[VERT_D2] - cx[VERT_C2];   // s
   assign by_in[CROSS_DEN] = cy[VERT_D2] - cy[VERT_C2];

   assign ax_in[CROSS_N1]  = cx[VERT_D2] - cx[VERT_C2];   // s
   assign ay_in[CROSS_N1]  = cy[VERT_D2] - cy[VERT_C2];
   assign bx_in[CROSS_N1]  = cx[VERT_D1] - cx[VERT_C2];   // w
   assign by_in[CROSS_N1]  = cy[VERT_D1] - cy[VERT_C2];

   assign ax_in[CROSS_N2]  = cx[VERT_A1] - cx[VERT_D1];   // r
   assign ay_in[CROSS_N2]  = cy[VERT_A1] - cy[VERT_D1];
   assign bx_in[CROSS_N2]  = cx[VERT_D1] - cx[VERT_C2];   // w
   assign by_in[CROSS_N2]  = cy[VERT_D1] - cy[VERT_C2];

   // Stage handshake
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_valid && up_ready) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
      end
   end

   assign dn_valid = valid_ff;
   assign ax = ax_ff;
   assign ay = ay_ff;
   assign bx = bx_ff;
   assign by = by_ff;

endmodule

`default_nettype wire

// ===== src/qqo_cross.sv =====
// ============================================================================
// qqo_cross
// Stages 2 and 3: the two products of each cross product, then their
// difference. One 17x17-class multiplier per product, registered.
// ============================================================================
`default_nettype none

module qqo_cross #(
   parameter int COORD_BITS = qqo_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // upstream
   input  wire logic up_valid,
   output logic      up_ready,
   input  wire logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] ax,
   input  wire logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] ay,
   input  wire logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] bx,
   input  wire logic [qqo_pkg::NUM_CROSS-1:0][qqo_pkg::coord_width(COORD_BITS):0] by,
   // downstream
   output logic      dn_valid,
   input  wire logic dn_ready,
   output logic [qqo_pkg::NUM_CROSS-1:0][2*qqo_pkg::coord_width(COORD_BITS)+2:0] crs
);
   import qqo_pkg::*;

   localparam int CW = coord_width(COORD_BITS);
   localparam int DW = CW + 1;         // operand bits
   localparam int PW = 2 * DW;         // product bits
   localparam int XW = PW + 1;         // cross product bits

   wire logic [NUM_CROSS-1:0][PW-1:0] p0_in;
   wire logic [NUM_CROSS-1:0][PW-1:0] p1_in;
   wire logic [NUM_CROSS-1:0][XW-1:0] crs_in;

   logic                          mul_valid_ff;
   logic                          mul_valid_in;
   logic                          mul_ready;
   logic [NUM_CROSS-1:0][PW-1:0]  p0_ff;
   logic [NUM_CROSS-1:0][PW-1:0]  p1_ff;

   logic                          sub_valid_ff;
   logic                          sub_valid_in;
   logic                          sub_ready;
   logic [NUM_CROSS-1:0][XW-1:0]  crs_ff;

   // Products x.a*y.b and y.a*x.b, signed
   for (genvar k = 0; k < NUM_CROSS; k++) begin : g_mul
      wire logic signed [DW-1:0] sax = ax[k];
      wire logic signed [DW-1:0] say = ay[k];
      wire logic signed [DW-1:0] sbx = bx[k];
      wire logic signed [DW-1:0] sby = by[k];
      wire logic signed [PW-1:0] m0  = sax * sby;
      wire logic signed [PW-1:0] m1  = say * sbx;
      assign p0_in[k] = m0;
      assign p1_in[k] = m1;
   end

   // Difference of the registered products
   for (genvar k = 0; k < NUM_CROSS; k++) begin : g_sub
      wire logic signed [XW-1:0] e0 = XW'($signed(p0_ff[k]));
      wire logic signed [XW-1:0] e1 = XW'($signed(p1_ff[k]));
      assign crs_in[k] = e0 - e1;
   end

   // Stage handshakes
   assign sub_ready    = !sub_valid_ff || dn_ready;
   assign mul_ready    = !mul_valid_ff || sub_ready;
   assign mul_valid_in = mul_ready ? up_valid : mul_valid_ff;
   assign sub_valid_in = sub_ready ? mul_valid_ff : sub_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sub_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         sub_valid_ff <= sub_valid_in;
      end
      if (up_valid && mul_ready) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
      if (mul_valid_ff && sub_ready) begin
         crs_ff <= crs_in;
      end
   end

   assign up_ready = mul_ready;
   assign dn_valid = sub_valid_ff;
   assign crs      = crs_ff;

   // Products held while the subtract stage is blocked
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && !sub_ready) |=>
         (mul_valid_ff && $stable(p0_ff) && $stable(p1_ff)))
      else $error("product stage changed while stalled");

   // Cross products held while downstream is blocked
   a_sub_hold: assert property (@(posedge clock) disable iff (reset)
      (sub_valid_ff && !dn_ready) |=> (sub_valid_ff && $stable(crs_ff)))
      else $error("cross stage changed while stalled");

   // A transaction leaving the product stage lands in the subtract stage
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && sub_ready) |=> sub_valid_ff)
      else $error("transaction lost between product and cross stages");

   // Zero operand gives a zero product on the segment denominator
   a_zero_prod: assert property (@(posedge clock) disable iff (reset)
      (up_valid && mul_ready && (ax[CROSS_DEN] == '0)) |=> (p0_ff[CROSS_DEN] == '0))
      else $error("nonzero product from zero operand");

endmodule

`default_nettype wire

// ===== src/qqo_decide.sv =====
// ============================================================================
// qqo_decide
// Stage 4: sign tests for point containment, closed-interval tests for the
// segment crossing, and the registered hit flag (the result register).
// ============================================================================
`default_nettype none

module qqo_decide #(
   parameter int COORD_BITS = qqo_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // upstream
   input  wire logic up_valid,
   output logic      up_ready,
   input  wire logic [qqo_pkg::NUM_CROSS-1:0][2*qqo_pkg::coord_width(COORD_BITS)+2:0] crs,
   // downstream
   output logic      dn_valid,
   input  wire logic dn_ready,
   output logic      hit
);
   import qqo_pkg::*;

   localparam int CW = coord_width(COORD_BITS);
   localparam int XW = 2 * (CW + 1) + 1;

   wire logic [NUM_POINTS-1:0] contained;
   wire logic signed [XW-1:0]  den;
   wire logic signed [XW-1:0]  n1;
   wire logic signed [XW-1:0]  n2;
   logic                       n1_ok;
   logic                       n2_ok;
   logic                       hit_in;

   logic valid_ff;
   logic valid_in;
   logic hit_ff;

   // Inside when no edge-side cross product is negative
   for (genvar pt = 0; pt < NUM_POINTS; pt++) begin : g_inside
      assign contained[pt] = !(crs[pt*QUAD_VERTS][XW-1]     ||
                               crs[pt*QUAD_VERTS + 1][XW-1] ||
                               crs[pt*QUAD_VERTS + 2][XW-1] ||
                               crs[pt*QUAD_VERTS + 3][XW-1]);
   end

   assign den = crs[CROSS_DEN];
   assign n1  = crs[CROSS_N1];
   assign n2  = crs[CROSS_N2];

   // Numerators within the closed interval between 0 and den
   always_comb begin
      if (den[XW-1]) begin
         n1_ok = (n1 <= 0) && (n1 >= den);
         n2_ok = (n2 <= 0) && (n2 >= den);
      end else begin
         n1_ok = (n1 >= 0) && (n1 <= den);
         n2_ok = (n2 >= 0) && (n2 <= den);
      end
      hit_in = (|contained) || (n1_ok && n2_ok);
   end

   // Result register
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_valid && up_ready) begin
         hit_ff <= hit_in;
      end
   end

   assign dn_valid = valid_ff;
   assign hit      = hit_ff;

endmodule

`default_nettype wire

// ===== tb/quad_quad_overlap_test_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// quad_quad_overlap_test_tb
// Self-checking bench for the quad/quad overlap test. A directed list covers
// coordinate extremes, both winding orders, containment either way, the
// D1-A1 / C2-D2 crossing with parallel, collinear and touching edges, and
// degenerate quads. Random quad pairs follow, mostly near each other so
// that hits and misses both occur, plus raw noise words. Every transaction
// is predicted in the bench or carries its own flag, and each flag is compared
// in order, under random stalls on both channels.
// ============================================================================

module quad_quad_overlap_test_tb;
   import qqo_pkg::*;

   localparam int COORD_BITS    = COORD_BITS_DEFAULT;
   localparam int COORD_W       = (COORD_BITS < HALF_BITS) ? COORD_BITS : HALF_BITS;
   localparam int RANDOM_ITEMS  = 935;
   localparam int QUIET_TAIL    = 120;   // final transactions sent with no idling
   localparam int HOLD_AT       = 300;   // long result back-pressure starts here
   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_AT      = 600;   // sender waits for an empty pipeline here
   localparam int SETTLE_CYCLES = 10;

   typedef logic [FIELD_BITS-1:0]                  vert_word_type;
   typedef logic [QUAD_VERTS-1:0][FIELD_BITS-1:0]  quad_type;
   typedef logic [NUM_VERTS-1:0][FIELD_BITS-1:0]   quad_pair_type;

   typedef struct {
      longint x;
      longint y;
   } point_type;

   // Directed rows either carry the flag outright or defer to the predictor
   typedef enum logic [1:0] {WANT_PREDICT, WANT_MISS, WANT_HIT} hit_want_type;

   typedef struct {
      quad_pair_type pair;
      hit_want_type  want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qqo_req_if req_ch ();
   qqo_rsp_if rsp_ch ();

   bit          hits_due [$];
   int unsigned fail_count = 0;
   bit          quiet_tail = 1'b0;
   bit          hold_rsp   = 1'b0;

   directed_row_type directed_rows [$];

   quad_quad_overlap_test #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Overlap predictor
   // ---------------------------------------------------------------------------

   // Sign-extend the low COORD_W bits of a half word
   function automatic longint coord_value(logic [HALF_BITS-1:0] half);
      longint v;
      v = longint'(half) & ((longint'(1) << COORD_W) - 1);
      if (v[COORD_W-1]) v -= longint'(1) << COORD_W;
      return v;
   endfunction

   function automatic point_type to_point(vert_word_type word);
      point_type p;
      p.x = coord_value(word[HALF_BITS-1:0]);
      p.y = coord_value(word[FIELD_BITS-1:HALF_BITS]);
      return p;
   endfunction

   function automatic point_type diff(point_type a, point_type b);
      point_type d;
      d.x = a.x - b.x;
      d.y = a.y - b.y;
      return d;
   endfunction

   function automatic longint cross_prod(point_type a, point_type b);
      return a.x * b.y - a.y * b.x;
   endfunction

   // Inside when every edge cross product is non-negative (one winding only)
   function automatic bit point_in_quad(input point_type pt [NUM_VERTS], input int base,
                                        input point_type p);
      point_type cur, nxt;
      for (int k = 0; k < QUAD_VERTS; k++) begin
         cur = pt[base + k];
         nxt = pt[base + (k + 1) % QUAD_VERTS];
         if (cross_prod(diff(nxt, cur), diff(p, nxt)) < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // n within the closed range between 0 and den; den of 0 needs n of 0
   function automatic bit in_span(longint n, longint den);
      if (den >= 0) return (n >= 0) && (n <= den);
      return (n <= 0) && (n >= den);
   endfunction

   function automatic bit predict_overlap(quad_pair_type pair);
      point_type pt [NUM_VERTS];
      point_type r, s, w;
      longint    den;
      bit        hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_VERTS; k++) pt[k] = to_point(pair[k]);
      for (int k = 0; k < QUAD_VERTS; k++) begin
         hit |= point_in_quad(pt, VERT_A1, pt[VERT_A2 + k]);
         hit |= point_in_quad(pt, VERT_A2, pt[VERT_A1 + k]);
      end
      // edge D1->A1 against edge C2->D2
      w   = diff(pt[VERT_D1], pt[VERT_C2]);
      r   = diff(pt[VERT_A1], pt[VERT_D1]);
      s   = diff(pt[VERT_D2], pt[VERT_C2]);
      den = cross_prod(r, s);
      hit |= in_span(cross_prod(s, w), den) && in_span(cross_prod(r, w), den);
      return hit;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic vert_word_type vtx(int x, int y);
      return {y[HALF_BITS-1:0], x[HALF_BITS-1:0]};
   endfunction

   function automatic quad_type quad(vert_word_type a, vert_word_type b,
                                     vert_word_type c, vert_word_type d);
      return {d, c, b, a};
   endfunction

   // Counter-clockwise when x0 < x1 and y0 < y1; swapping x gives clockwise
   function automatic quad_type box(int x0, int y0, int x1, int y1);
      return quad(vtx(x0, y0), vtx(x1, y0), vtx(x1, y1), vtx(x0, y1));
   endfunction

   function automatic int spread(int j);
      return int'($urandom_range(0, 2 * j)) - j;
   endfunction

   // Jittered box around a center, one in five wound clockwise
   function automatic quad_type rand_quad(int cx, int cy, int span);
      int       xs [QUAD_VERTS];
      int       ys [QUAD_VERTS];
      int       hw, hh, jit, idx;
      bit       cw;
      quad_type q;
      hw  = $urandom_range(0, span);
      hh  = $urandom_range(0, span);
      jit = span / 4 + 1;
      cw  = ($urandom_range(0, 4) == 0);
      xs  = '{cx - hw, cx + hw, cx + hw, cx - hw};
      ys  = '{cy - hh, cy - hh, cy + hh, cy + hh};
      for (int k = 0; k < QUAD_VERTS; k++) begin
         idx  = cw ? (QUAD_VERTS - 1 - k) : k;
         q[k] = vtx(xs[idx] + spread(jit), ys[idx] + spread(jit));
      end
      return q;
   endfunction

   task automatic add_row(quad_type one, quad_type two, hit_want_type want);
      directed_rows.push_back('{pair: {two, one}, want: want});
   endtask

   // Offer one transaction, record its flag on acceptance, maybe idle after
   task automatic offer_pair(quad_pair_type pair, bit hit_want);
      req_ch.valid      <= 1'b1;
      req_ch.quad_one_a <= pair[VERT_A1];
      req_ch.quad_one_b <= pair[VERT_A1 + 1];
      req_ch.quad_one_c <= pair[VERT_A1 + 2];
      req_ch.quad_one_d <= pair[VERT_D1];
      req_ch.quad_two_a <= pair[VERT_A2];
      req_ch.quad_two_b <= pair[VERT_A2 + 1];
      req_ch.quad_two_c <= pair[VERT_C2];
      req_ch.quad_two_d <= pair[VERT_D2];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      hits_due.push_back(hit_want);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   initial begin : req_drive
      quad_pair_type pair;
      quad_type      one, two;
      hit_want_type  want;
      int            kind, span, cx, cy;

      req_ch.valid      <= 1'b0;
      req_ch.quad_one_a <= '0;
      req_ch.quad_one_b <= '0;
      req_ch.quad_one_c <= '0;
      req_ch.quad_one_d <= '0;
      req_ch.quad_two_a <= '0;
      req_ch.quad_two_b <= '0;
      req_ch.quad_two_c <= '0;
      req_ch.quad_two_d <= '0;

      // coincident points: every cross product is zero
      add_row('0, '0, WANT_HIT);
      add_row('1, '1, WANT_HIT);
      add_row({4{vtx(32767, 32767)}}, {4{vtx(32767, 32767)}}, WANT_HIT);
      add_row({4{vtx(-32768, -32768)}}, {4{vtx(-32768, -32768)}}, WANT_HIT);
      // full-range square around a small one, both windings
      add_row(box(-32768, -32768, 32767, 32767), box(-10, -10, 10, 10), WANT_PREDICT);
      add_row(box(32767, -32768, -32768, 32767), box(-10, -10, 10, 10), WANT_PREDICT);
      // opposite corners of the coordinate range
      add_row(box(-32768, -32768, -32760, -32760), box(32760, 32760, 32767, 32767),
              WANT_PREDICT);
      // disjoint, second contains first, plus-shaped overlap
      add_row(box(0, 0, 10, 10), box(100, 100, 120, 120), WANT_PREDICT);
      add_row(box(0, 0, 5, 5), box(-100, -100, 100, 100), WANT_PREDICT);
      add_row(box(0, 0, 100, 10), box(40, -50, 60, 60), WANT_PREDICT);
      // D1-A1 crosses C2-D2 at the origin
      add_row(quad(vtx(0, -20), vtx(-30, -40), vtx(-40, -30), vtx(0, 20)),
              quad(vtx(-20, 60), vtx(20, 60), vtx(20, 0), vtx(-20, 0)), WANT_PREDICT);
      // collinear overlapping edges: zero denominator, zero numerators
      add_row(quad(vtx(10, 0), vtx(10, -50), vtx(-40, -50), vtx(0, 0)),
              quad(vtx(60, 40), vtx(30, 40), vtx(5, 0), vtx(15, 0)), WANT_PREDICT);
      // parallel edges apart: zero denominator, non-zero numerator
      add_row(quad(vtx(10, 0), vtx(10, -50), vtx(-40, -50), vtx(0, 0)),
              quad(vtx(60, 40), vtx(30, 40), vtx(0, 5), vtx(10, 5)), WANT_PREDICT);
      // edges touching at one endpoint
      add_row(quad(vtx(10, 0), vtx(10, -50), vtx(-40, -50), vtx(0, 0)),
              quad(vtx(60, 40), vtx(30, 40), vtx(10, 0), vtx(10, 10)), WANT_PREDICT);
      // degenerate quads: a single point, four collinear vertices
      add_row({4{vtx(3, 3)}}, box(0, 0, 10, 10), WANT_PREDICT);
      add_row(quad(vtx(0, 0), vtx(1, 1), vtx(2, 2), vtx(3, 3)), box(-5, -5, 5, 5),
              WANT_PREDICT);
      // alternating bit patterns
      add_row(quad(32'hAAAA5555, 32'h5555AAAA, 32'h55555555, 32'hAAAAAAAA),
              quad(32'h5555AAAA, 32'hAAAA5555, 32'hAAAAAAAA, 32'h55555555), WANT_PREDICT);

      while (reset) @(posedge clock);

      foreach (directed_rows[i]) begin
         pair = directed_rows[i].pair;
         want = directed_rows[i].want;
         offer_pair(pair, (want == WANT_PREDICT) ? predict_overlap(pair)
                                                 : (want == WANT_HIT));
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_tail = (n >= RANDOM_ITEMS - QUIET_TAIL);
         if (n == HOLD_AT) hold_rsp = 1'b1;
         if (n == DRAIN_AT) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (hits_due.size() != 0);
         end

         kind = $urandom_range(0, 9);
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30000)
                                            : $urandom_range(1, 300);
         cx   = int'($urandom_range(0, 65535)) - 32768;
         cy   = int'($urandom_range(0, 65535)) - 32768;
         one  = rand_quad(cx, cy, span);
         two  = rand_quad(cx + spread(2 * span + 2), cy + spread(2 * span + 2), span);

         case (kind)
            0: begin
               // raw noise across every bit
               for (int k = 0; k < QUAD_VERTS; k++) begin
                  one[k] = $urandom;
                  two[k] = $urandom;
               end
            end
            1: begin
               // a vertex shared between the quads
               two[$urandom_range(0, QUAD_VERTS - 1)] = one[$urandom_range(0, QUAD_VERTS - 1)];
            end
            2: begin
               // C2-D2 laid over D1-A1, reversed
               two[VERT_C2 - VERT_A2] = one[VERT_A1];
               two[VERT_D2 - VERT_A2] = one[VERT_D1];
            end
            default: ;
         endcase

         pair = {two, one};
         offer_pair(pair, predict_overlap(pair));
      end

      // wait out the pipeline, then idle for SETTLE_CYCLES to catch stray results
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (hits_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side: random stall bursts, one long hold-off
   // ---------------------------------------------------------------------------
   initial begin : rsp_drain
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted result with the oldest pending flag
   always @(posedge clock) begin : hit_check
      bit want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (hits_due.size() == 0) begin
            $error("overlap_hit: result with no transaction pending, actual %0b",
                   rsp_ch.overlap_hit);
            fail_count++;
         end else begin
            want = hits_due.pop_front();
            if (rsp_ch.overlap_hit !== want) begin
               $error("overlap_hit mismatch: expected %0b, actual %0b",
                      want, rsp_ch.overlap_hit);
               fail_count++;
            end
         end
      end
   end

endmodule
